/* rtl/core/xyb_pkg.sv */
// shared types and constants of the xy beam position and colour unit
// used by every module in rtl/core; depends on nothing else
package xyb_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_ENABLE      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RC_TIME_US       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_WAIT_US    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_ENABLE   = 3'd6;

    // field widths
    localparam int POS_BITS   = 15;
    localparam int WAIT_BITS  = 16;
    localparam int LEVEL_BITS = 8;
    localparam int CHAN_BITS  = 4;

    // result transaction: 82 field bits padded to 11 bytes
    localparam int OUT_TDATA_BITS = 88;

    // command and result codes
    localparam logic ACTION_MOVE   = 1'b0;
    localparam logic ACTION_COLOR  = 1'b1;
    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_COLOR    = 1'b1;

    // arithmetic constants
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [15:0] LUMA_RECIP   = 16'd41944;   // ceil(2^22 / 100)
    localparam int          LUMA_SHIFT   = 22;
    localparam logic [15:0] WAIT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [POS_BITS-1:0] screen_width;
        logic [POS_BITS-1:0] screen_height;
        logic                wrap_enable;
    } cfg_front_t;

    typedef struct packed {
        logic [WAIT_BITS-1:0] rc_time_us;
        logic [WAIT_BITS-1:0] settle_threshold;
        logic [WAIT_BITS-1:0] color_wait_us;
        logic [CHAN_BITS-1:0] channel_enable;
    } cfg_back_t;

    // classified command passed from front to back
    typedef struct packed {
        logic                  is_color;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
        logic [LEVEL_BITS-1:0] red;
        logic [LEVEL_BITS-1:0] green;
        logic [LEVEL_BITS-1:0] blue;
    } cmd_t;

endpackage

/* rtl/core/xyb_front.sv */
// front end: accepts input transactions, classifies them and fits move targets
// depends on xyb_pkg
module xyb_front import xyb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_front_t                cfg,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_tdata,
    input  logic                      s_tuser,
    output logic                      push_valid,
    input  logic                      push_ready,
    output cmd_t                      push_cmd
);

    localparam int CMP_BITS = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int CNT_BITS = $clog2(COORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COORD_BITS - 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [COORD_BITS-1:0] mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic [POS_BITS-1:0]   rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [POS_BITS-1:0]   size_x_reg, size_x_next, size_y_reg, size_y_next;
    logic                  neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic signed [COORD_BITS-1:0] tx, ty;
    logic [POS_BITS-1:0]   size_x, size_y, rx, ry;

    // clamp a signed coordinate to 0 .. size-1
    function automatic logic [POS_BITS-1:0] clamp_coord(
        input logic signed [COORD_BITS-1:0] v, input logic [POS_BITS-1:0] size);
        logic [CMP_BITS-1:0] vu;
        vu = CMP_BITS'($unsigned(v));
        if (v[COORD_BITS-1])
            return '0;
        else if (vu >= CMP_BITS'(size))
            return size - 1'b1;
        else
            return vu[POS_BITS-1:0];
    endfunction

    // one restoring step of the magnitude remainder
    function automatic logic [POS_BITS-1:0] mod_step(
        input logic [POS_BITS-1:0] rem, input logic bit_in,
        input logic [POS_BITS-1:0] size);
        logic [POS_BITS:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, size})
            t = t - {1'b0, size};
        return t[POS_BITS-1:0];
    endfunction

    // turn a magnitude remainder into a non-negative modulo
    function automatic logic [POS_BITS-1:0] wrap_fix(
        input logic [POS_BITS-1:0] rem, input logic neg,
        input logic [POS_BITS-1:0] size);
        if (neg && (rem != '0))
            return size - rem;
        else
            return rem;
    endfunction

    // input field extraction
    assign tx = s_tdata[COORD_BITS-1:0];
    assign ty = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign size_x = (cfg.screen_width  == '0) ? POS_BITS'(1) : cfg.screen_width;
    assign size_y = (cfg.screen_height == '0) ? POS_BITS'(1) : cfg.screen_height;
    assign rx = mod_step(rem_x_reg, mag_x_reg[COORD_BITS-1], size_x_reg);
    assign ry = mod_step(rem_y_reg, mag_y_reg[COORD_BITS-1], size_y_reg);

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_cmd   = cmd_reg;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        mag_x_next  = mag_x_reg;
        mag_y_next  = mag_y_reg;
        rem_x_next  = rem_x_reg;
        rem_y_next  = rem_y_reg;
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    cmd_next.is_color = (s_tuser == ACTION_COLOR);
                    cmd_next.red      = s_tdata[2*COORD_BITS +: LEVEL_BITS];
                    cmd_next.green    = s_tdata[2*COORD_BITS+8 +: LEVEL_BITS];
                    cmd_next.blue     = s_tdata[2*COORD_BITS+16 +: LEVEL_BITS];
                    cmd_next.pos_x    = clamp_coord(tx, size_x);
                    cmd_next.pos_y    = clamp_coord(ty, size_y);
                    neg_x_next  = tx[COORD_BITS-1];
                    neg_y_next  = ty[COORD_BITS-1];
                    mag_x_next  = tx[COORD_BITS-1] ? (~tx + 1'b1) : tx;
                    mag_y_next  = ty[COORD_BITS-1] ? (~ty + 1'b1) : ty;
                    rem_x_next  = '0;
                    rem_y_next  = '0;
                    size_x_next = size_x;
                    size_y_next = size_y;
                    cnt_next    = '0;
                    if ((s_tuser == ACTION_MOVE) && cfg.wrap_enable)
                        state_next = F_DIV;
                    else
                        state_next = F_PUSH;
                end
            end
            F_DIV: begin
                mag_x_next = {mag_x_reg[COORD_BITS-2:0], 1'b0};
                mag_y_next = {mag_y_reg[COORD_BITS-2:0], 1'b0};
                rem_x_next = rx;
                rem_y_next = ry;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cmd_next.pos_x = wrap_fix(rx, neg_x_reg, size_x_reg);
                    cmd_next.pos_y = wrap_fix(ry, neg_y_reg, size_y_reg);
                    state_next     = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        rem_x_reg  <= rem_x_next;
        rem_y_reg  <= rem_y_next;
        size_x_reg <= size_x_next;
        size_y_reg <= size_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        cnt_reg    <= cnt_next;
    end

endmodule

/* rtl/core/xyb_queue.sv */
// two-entry command queue between front and back
// depends on xyb_pkg
module xyb_queue import xyb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    cmd_t       entry_reg [2];
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/core/xyb_back.sv */
// back end: cursor, settle wait log sequencer, colour levels, output register
// depends on xyb_pkg
module xyb_back import xyb_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_back_t                 cfg,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  cmd_t                      pop_cmd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    output logic                      m_tuser
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_CHECK = 3'd1;
    localparam logic [2:0] B_DIV   = 3'd2;
    localparam logic [2:0] B_SQ    = 3'd3;
    localparam logic [2:0] B_LN    = 3'd4;
    localparam logic [2:0] B_W     = 3'd5;
    localparam logic [2:0] B_LUMA  = 3'd6;
    localparam logic [2:0] B_OUT   = 3'd7;

    localparam logic [4:0] DIV_LAST = 5'd29;
    localparam logic [4:0] SQ_LAST  = 5'd15;

    logic [2:0]            state_reg, state_next;
    logic [POS_BITS-1:0]   cursor_x_reg, cursor_x_next, cursor_y_reg, cursor_y_next;
    logic [POS_BITS-1:0]   delta_reg, delta_next, d_reg, d_next, rem_reg, rem_next;
    logic [4:0]            n_reg, n_next, cnt_reg, cnt_next;
    logic [30:0]           m_reg, m_next;
    logic [15:0]           frac_reg, frac_next;
    logic [20:0]           lnq_reg, lnq_next;
    logic [14:0]           sum_reg, sum_next;
    logic [LEVEL_BITS-1:0] red_reg, red_next, green_reg, green_next;
    logic [LEVEL_BITS-1:0] blue_reg, blue_next, luma_reg, luma_next;
    logic                  kind_reg, kind_next;
    logic [WAIT_BITS-1:0]  wait_reg, wait_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;
    logic                  out_kind_reg, out_kind_next;

    logic [POS_BITS-1:0]   dx, dy;
    logic [35:0]           thr_wide, delta_wide;
    logic [4:0]            n_val;
    logic [35:0]           d_wide;
    logic [POS_BITS:0]     div_t;
    logic [61:0]           sq;
    logic [31:0]           sq_top;
    logic [52:0]           ln_prod;
    logic [36:0]           w_prod;
    logic [30:0]           luma_prod;
    logic                  load_out;

    // distance from the cursor to the new target
    assign dx = (pop_cmd.pos_x > cursor_x_reg) ? pop_cmd.pos_x - cursor_x_reg
                                               : cursor_x_reg - pop_cmd.pos_x;
    assign dy = (pop_cmd.pos_y > cursor_y_reg) ? pop_cmd.pos_y - cursor_y_reg
                                               : cursor_y_reg - pop_cmd.pos_y;

    // integer part of log2(delta / threshold)
    assign thr_wide   = 36'(cfg.settle_threshold);
    assign delta_wide = 36'(delta_reg);
    always_comb begin
        n_val = '0;
        for (int k = 1; k <= 20; k++) begin
            if ((thr_wide << k) <= delta_wide)
                n_val = 5'(k);
        end
    end
    assign d_wide = thr_wide << n_val;

    // datapath terms
    assign div_t     = {rem_reg, 1'b0};
    assign sq        = 62'(m_reg) * 62'(m_reg);
    assign sq_top    = sq[61:30];
    assign ln_prod   = 53'({n_reg, frac_reg}) * 53'(LN2_Q32) + 53'(64'h8000_0000);
    assign w_prod    = 37'(cfg.rc_time_us) * 37'(lnq_reg) + 37'(16'hFFFF);
    assign luma_prod = 31'(sum_reg) * 31'(LUMA_RECIP);

    assign pop_ready = (state_reg == B_IDLE);
    assign load_out  = (state_reg == B_OUT) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        delta_next    = delta_reg;
        d_next        = d_reg;
        rem_next      = rem_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        lnq_next      = lnq_reg;
        sum_next      = sum_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        luma_next     = luma_reg;
        kind_next     = kind_reg;
        wait_next     = wait_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    red_next   = pop_cmd.red;
                    green_next = pop_cmd.green;
                    blue_next  = pop_cmd.blue;
                    if (pop_cmd.is_color) begin
                        kind_next  = KIND_COLOR;
                        sum_next   = 15'(pop_cmd.red) * 15'd21 + 15'(pop_cmd.green) * 15'd72
                                   + 15'(pop_cmd.blue) * 15'd7;
                        state_next = B_LUMA;
                    end else begin
                        kind_next     = KIND_POSITION;
                        delta_next    = (dx > dy) ? dx : dy;
                        cursor_x_next = pop_cmd.pos_x;
                        cursor_y_next = pop_cmd.pos_y;
                        state_next    = B_CHECK;
                    end
                end
            end
            B_CHECK: begin
                if ({1'b0, delta_reg} <= cfg.settle_threshold) begin
                    wait_next  = 16'd1;
                    state_next = B_OUT;
                end else if (cfg.settle_threshold == '0) begin
                    wait_next  = (cfg.rc_time_us == '0) ? '0 : WAIT_MAX;
                    state_next = B_OUT;
                end else begin
                    n_next     = n_val;
                    d_next     = d_wide[POS_BITS-1:0];
                    rem_next   = delta_reg - d_wide[POS_BITS-1:0];
                    m_next     = 31'd1;
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                // mantissa delta / (threshold << n) in q1.30, one bit a cycle
                if (div_t >= {1'b0, d_reg}) begin
                    rem_next = POS_BITS'(div_t - {1'b0, d_reg});
                    m_next   = {m_reg[29:0], 1'b1};
                end else begin
                    rem_next = div_t[POS_BITS-1:0];
                    m_next   = {m_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    frac_next  = '0;
                    state_next = B_SQ;
                end
            end
            B_SQ: begin
                // one fraction bit of log2 per squaring
                frac_next = {frac_reg[14:0], sq_top[31]};
                m_next    = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST)
                    state_next = B_LN;
            end
            B_LN: begin
                lnq_next   = ln_prod[52:32];
                state_next = B_W;
            end
            B_W: begin
                wait_next  = (w_prod[36:32] != '0) ? WAIT_MAX : w_prod[31:16];
                state_next = B_OUT;
            end
            B_LUMA: begin
                luma_next  = luma_prod[LUMA_SHIFT +: LEVEL_BITS];
                wait_next  = cfg.color_wait_us;
                state_next = B_OUT;
            end
            B_OUT: begin
                if (load_out)
                    state_next = B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_kind_next  = kind_reg;
            if (kind_reg == KIND_COLOR)
                out_data_next = {6'b0, cfg.channel_enable, ~luma_reg, ~blue_reg,
                                 ~green_reg, ~red_reg, wait_reg, cursor_y_reg, cursor_x_reg};
            else
                out_data_next = {6'b0, 4'b0, 32'b0, wait_reg, cursor_y_reg, cursor_x_reg};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg    <= delta_next;
        d_reg        <= d_next;
        rem_reg      <= rem_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        lnq_reg      <= lnq_next;
        sum_reg      <= sum_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        luma_reg     <= luma_next;
        kind_reg     <= kind_next;
        wait_reg     <= wait_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

endmodule

/* rtl/core/xy_beam_position_and_color.sv */
// top level of the xy beam position and colour unit: registers, front, queue, back
// depends on xyb_pkg, xyb_front, xyb_queue, xyb_back
//
// usage
// - s_ channel takes one command per transaction: tuser is the action (move or
//   colour), tdata carries target_x, target_y, red, green, blue
// - m_ channel returns one result per command: tuser is the kind, tdata carries
//   the cursor, the wait, the four inverted levels and the level update mask
// - cfg_wr_en / cfg_index / cfg_wdata write one register per cycle, no read-back;
//   write only while no command is in flight
// - a colour command, and a move whose delta is within the threshold, skip the
//   log sequence; other moves with a nonzero threshold run it (30-step mantissa
//   division, 16 squarings, two multiplies); with wrap on, the front first
//   reduces a move target modulo the screen size
// - throughput is one command per back end pass, set by the log sequencer; the
//   front and a two-entry queue take further commands meanwhile
// - reset clears the cursor to 0, the registers to their defaults and empties
//   the queue and output register
// - when m_tready is low the finished result holds in the output register and
//   the back end stops before the next result; the queue then fills and
//   s_tready falls
module xy_beam_position_and_color import xyb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // target_x, target_y, red_in, green_in, blue_in, zero padding
    input  logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_tdata,
    // action
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pos_x, pos_y, wait_us, red_level, green_level, blue_level, luma_level,
    // level_update, zero padding
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    // kind
    output logic                      m_tuser
);

    logic [POS_BITS-1:0]  screen_width_reg, screen_height_reg;
    logic                 wrap_enable_reg;
    logic [WAIT_BITS-1:0] rc_time_us_reg, settle_threshold_reg, color_wait_us_reg;
    logic [CHAN_BITS-1:0] channel_enable_reg;

    cfg_front_t cfg_front;
    cfg_back_t  cfg_back;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    cmd_t       push_cmd, pop_cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg     <= 15'd256;
            screen_height_reg    <= 15'd256;
            wrap_enable_reg      <= 1'b0;
            rc_time_us_reg       <= 16'd1;
            settle_threshold_reg <= 16'd1;
            color_wait_us_reg    <= 16'd0;
            channel_enable_reg   <= 4'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:     screen_width_reg     <= cfg_wdata[POS_BITS-1:0];
                REG_SCREEN_HEIGHT:    screen_height_reg    <= cfg_wdata[POS_BITS-1:0];
                REG_WRAP_ENABLE:      wrap_enable_reg      <= cfg_wdata[0];
                REG_RC_TIME_US:       rc_time_us_reg       <= cfg_wdata;
                REG_SETTLE_THRESHOLD: settle_threshold_reg <= cfg_wdata;
                REG_COLOR_WAIT_US:    color_wait_us_reg    <= cfg_wdata;
                REG_CHANNEL_ENABLE:   channel_enable_reg   <= cfg_wdata[CHAN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_front = '{screen_width: screen_width_reg, screen_height: screen_height_reg,
                         wrap_enable: wrap_enable_reg};
    assign cfg_back  = '{rc_time_us: rc_time_us_reg, settle_threshold: settle_threshold_reg,
                         color_wait_us: color_wait_us_reg,
                         channel_enable: channel_enable_reg};

    xyb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_front),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    xyb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    xyb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_back),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // after accepting a command the front is not ready in the cycle that follows
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front accepted two commands in consecutive cycles");

    // position results carry no levels and no update mask
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_POSITION)) |-> (m_tdata[81:46] == '0))
        else $error("position result with level fields set");

    // colour results report the enabled channels
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_COLOR)) |-> (m_tdata[81:78] == channel_enable_reg))
        else $error("colour result with wrong update mask");

    // a fitted x coordinate lies on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_POSITION)) |->
        ((m_tdata[14:0] < screen_width_reg) || (m_tdata[14:0] == '0)))
        else $error("position x off screen");

endmodule

/* sim/xy_beam_position_and_color_test.sv */
// self-checking bench for the xy beam position and colour unit
// depends on xyb_pkg and the xy_beam_position_and_color rtl
module xy_beam_position_and_color_test;
    import xyb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int IN_BITS = ((2*CB+24+7)/8)*8;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic        kind;
        logic [14:0] px;
        logic [14:0] py;
        logic [15:0] wt;
        logic [7:0]  rl, gl, bl, ll;
        logic [3:0]  upd;
    } beam_result_t;

    typedef struct {
        logic        act;
        logic [15:0] tx, ty;
        logic [7:0]  r, g, b;
        logic        has_exp;
        beam_result_t exp_res;
    } cmd_row_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 0, s_tready, s_tuser = 0;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0, m_tuser;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    xy_beam_position_and_color #(.COORD_BITS(CB)) dut (.*);

    // predictor copy of registers and cursor
    logic [14:0] p_width, p_height, cur_x, cur_y;
    logic        p_wrap;
    logic [15:0] p_rc, p_thr, p_cwait;
    logic [3:0]  p_chan;

    beam_result_t pending_results[$];
    int mismatches = 0, checked = 0, cycles = 0;
    int send_idle = 10, recv_idle = 70;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("xy_beam_position_and_color test failed");
            $finish;
        end
    end

    function automatic logic [14:0] fit_axis(logic signed [15:0] v, logic [14:0] size);
        longint s, r;
        s = (size == 0) ? 1 : size;
        if (p_wrap) begin
            r = longint'(v) % s;
            if (r < 0) r += s;
            return r[14:0];
        end
        if (longint'(v) >= s) return 15'(s - 1);
        if (v < 0) return 15'd0;
        return v[14:0];
    endfunction

    function automatic logic [15:0] settle_time(longint unsigned delta);
        longint unsigned thr, m, lg, lnq, w;
        int n;
        thr = p_thr;
        if (delta <= thr) return 16'd1;
        if (thr == 0) return (p_rc == 0) ? 16'd0 : 16'hFFFF;
        n = 0;
        while (n < 20 && (thr << (n + 1)) <= delta) n++;
        m = (delta << 30) / (thr << n);
        lg = longint'(n) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                lg |= 64'd1 << i;
                m >>= 1;
            end
        end
        lnq = (lg * 64'd2977044472 + (64'd1 << 31)) >> 32;
        w = (longint'(p_rc) * lnq + 65535) >> 16;
        return (w > 65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic beam_result_t predict_beam(cmd_row_t c);
        beam_result_t o;
        logic [14:0] nx, ny, dx, dy;
        int z;
        o = '0;
        if (c.act == ACTION_MOVE) begin
            nx = fit_axis(c.tx, p_width);
            ny = fit_axis(c.ty, p_height);
            dx = (nx > cur_x) ? nx - cur_x : cur_x - nx;
            dy = (ny > cur_y) ? ny - cur_y : cur_y - ny;
            o.wt = settle_time((dx > dy) ? dx : dy);
            cur_x = nx;
            cur_y = ny;
            o.kind = KIND_POSITION;
        end else begin
            z = (c.r * 21 + c.g * 72 + c.b * 7) / 100;
            o.kind = KIND_COLOR;
            o.wt = p_cwait;
            o.rl = 8'(255 - c.r);
            o.gl = 8'(255 - c.g);
            o.bl = 8'(255 - c.b);
            o.ll = 8'(255 - z);
            o.upd = p_chan;
        end
        o.px = cur_x;
        o.py = cur_y;
        return o;
    endfunction

    // result checking
    always @(posedge aclk) begin
        beam_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.px   = m_tdata[14:0];
            got.py   = m_tdata[29:15];
            got.wt   = m_tdata[45:30];
            got.rl   = m_tdata[53:46];
            got.gl   = m_tdata[61:54];
            got.bl   = m_tdata[69:62];
            got.ll   = m_tdata[77:70];
            got.upd  = m_tdata[81:78];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_SCREEN_WIDTH:     p_width = val[14:0];
            REG_SCREEN_HEIGHT:    p_height = val[14:0];
            REG_WRAP_ENABLE:      p_wrap = val[0];
            REG_RC_TIME_US:       p_rc = val;
            REG_SETTLE_THRESHOLD: p_thr = val;
            REG_COLOR_WAIT_US:    p_cwait = val;
            REG_CHANNEL_ENABLE:   p_chan = val[3:0];
            default: ;
        endcase
    endtask

    task automatic send_cmd(cmd_row_t c);
        beam_result_t e;
        while ($urandom_range(99) < send_idle) @(posedge aclk);
        e = predict_beam(c);
        if (c.has_exp && e !== c.exp_res) begin
            mismatches++;
            if (mismatches <= 10) $display("predictor disagrees: %h vs %h", c.exp_res, e);
        end
        pending_results.push_back(c.has_exp ? c.exp_res : e);
        s_tvalid <= 1;
        s_tuser <= c.act;
        s_tdata <= {c.b, c.g, c.r, c.ty, c.tx};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 0;
        // the front is busy in the cycle after a transaction
        @(posedge aclk);
    endtask

    task automatic drain;
        int guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (100) @(posedge aclk);
    endtask

    function automatic cmd_row_t mk(logic a, int x, int y, int r, int g, int b);
        cmd_row_t c;
        c.act = a; c.tx = 16'(x); c.ty = 16'(y); c.r = 8'(r); c.g = 8'(g); c.b = 8'(b);
        c.has_exp = 0; c.exp_res = '0;
        return c;
    endfunction

    function automatic cmd_row_t rand_cmd();
        cmd_row_t c;
        c = mk(1'($urandom_range(1)), 0, 0, $urandom_range(255), $urandom_range(255),
               $urandom_range(255));
        case ($urandom_range(3))
            0: begin c.tx = 16'($urandom); c.ty = 16'($urandom); end
            1: begin
                c.tx = 16'($urandom_range(p_width + 4));
                c.ty = 16'($urandom_range(p_height + 4));
            end
            2: begin c.tx = 16'(-$urandom_range(300)); c.ty = 16'(-$urandom_range(300)); end
            default: begin c.tx = 16'(cur_x + $urandom_range(8)); c.ty = 16'(cur_y); end
        endcase
        return c;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) send_cmd(rand_cmd());
        drain();
    endtask

    initial begin
        cmd_row_t rows[$];
        cmd_row_t c;
        p_width = 256; p_height = 256; p_wrap = 0; p_rc = 1; p_thr = 1;
        p_cwait = 0; p_chan = 0; cur_x = 0; cur_y = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;

        // directed table: reset values, extremes, special cases
        c = mk(ACTION_COLOR, 0, 0, 0, 0, 0);
        c.has_exp = 1;
        c.exp_res = '{KIND_COLOR, 0, 0, 0, 255, 255, 255, 255, 0};
        rows.push_back(c);
        c = mk(ACTION_COLOR, 0, 0, 255, 255, 255);
        c.has_exp = 1;
        c.exp_res = '{KIND_COLOR, 0, 0, 0, 0, 0, 0, 0, 0};
        rows.push_back(c);
        c = mk(ACTION_MOVE, 1, 0, 0, 0, 0);   // within threshold
        c.has_exp = 1;
        c.exp_res = '{KIND_POSITION, 1, 0, 1, 0, 0, 0, 0, 0};
        rows.push_back(c);
        c = mk(ACTION_MOVE, 32767, 32767, 0, 0, 0);   // clamp high
        c.has_exp = 1; c.exp_res = '{KIND_POSITION, 255, 255, 6, 0, 0, 0, 0, 0};
        rows.push_back(c);
        c = mk(ACTION_MOVE, -32768, -32768, 0, 0, 0);   // clamp low
        c.has_exp = 1; c.exp_res = '{KIND_POSITION, 0, 0, 6, 0, 0, 0, 0, 0};
        rows.push_back(c);
        rows.push_back(mk(ACTION_MOVE, 100, 3, 0, 0, 0));
        rows.push_back(mk(ACTION_COLOR, 0, 0, 170, 85, 51));
        foreach (rows[i]) send_cmd(rows[i]);
        drain();

        // wrap, zero threshold, big rc
        write_reg(REG_WRAP_ENABLE, 1);
        write_reg(REG_SETTLE_THRESHOLD, 0);
        write_reg(REG_RC_TIME_US, 16'hFFFF);
        write_reg(REG_CHANNEL_ENABLE, 4'hF);
        write_reg(REG_COLOR_WAIT_US, 16'hFFFF);
        send_cmd(mk(ACTION_MOVE, -1, -257, 0, 0, 0));
        send_cmd(mk(ACTION_MOVE, -32768, 32767, 0, 0, 0));
        send_cmd(mk(ACTION_COLOR, 0, 0, 1, 2, 4));
        drain();
        write_reg(REG_RC_TIME_US, 0);
        send_cmd(mk(ACTION_MOVE, 7, 9, 0, 0, 0));
        drain();
        write_reg(REG_SCREEN_WIDTH, 0);   // zero size behaves as one
        write_reg(REG_SCREEN_HEIGHT, 1);
        send_cmd(mk(ACTION_MOVE, 1234, -5, 0, 0, 0));
        drain();

        // random phases across settings and idling patterns
        write_reg(REG_SCREEN_WIDTH, 16'h7FFF);
        write_reg(REG_SCREEN_HEIGHT, 16'h7FFF);
        write_reg(REG_WRAP_ENABLE, 0);
        write_reg(REG_RC_TIME_US, 1000);
        write_reg(REG_SETTLE_THRESHOLD, 1);
        write_reg(REG_CHANNEL_ENABLE, 4'h5);
        write_reg(REG_COLOR_WAIT_US, 250);
        random_phase(130);
        send_idle = 70; recv_idle = 10;
        write_reg(REG_SCREEN_WIDTH, 640);
        write_reg(REG_SCREEN_HEIGHT, 480);
        write_reg(REG_WRAP_ENABLE, 1);
        write_reg(REG_SETTLE_THRESHOLD, 16'hFFFF);
        write_reg(REG_RC_TIME_US, 37);
        random_phase(130);
        send_idle = 0; recv_idle = 0;
        write_reg(REG_SETTLE_THRESHOLD, 3);
        write_reg(REG_WRAP_ENABLE, 0);
        write_reg(REG_CHANNEL_ENABLE, 4'hA);
        random_phase(140);

        $display("covered %0d results over clamp, wrap, zero size and threshold settings",
                 checked);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("xy_beam_position_and_color test passed");
        else
            $display("xy_beam_position_and_color test failed");
        $finish;
    end
endmodule
